// File: hw/rtl/hkr_pkg.sv
// ---------------------------------------------------------------------------
// hkr_pkg: shared types and mod-26 helpers for 2x2 Hill key recovery
// Letter arithmetic, reciprocal-multiply reduction and the unit inverse table.
// ---------------------------------------------------------------------------
package hkr_pkg;

  localparam int unsigned Letters  = 26;
  localparam int unsigned LetterW  = 5;
  localparam int unsigned ProdW    = 2 * LetterW;
  // floor(x/26) estimate: (x * 157) >> 12, never above the true quotient
  localparam int unsigned Recip    = 157;
  localparam int unsigned RecipW   = 8;
  localparam int unsigned ScaledW  = ProdW + RecipW;
  localparam int unsigned QuotSh   = 12;
  localparam int unsigned QuotW    = ScaledW - QuotSh;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [ProdW-1:0]   prod_t;

  // Front end result: pieces of P needed for the adjugate, C, det inverse
  typedef struct packed {
    letter_t a;
    letter_t d;
    letter_t nb;
    letter_t nc;
    letter_t e;
    letter_t f;
    letter_t g;
    letter_t h;
    letter_t dinv;
    logic    ok;
  } det_res_t;

  // P^-1 entries plus C
  typedef struct packed {
    letter_t i00;
    letter_t i01;
    letter_t i10;
    letter_t i11;
    letter_t e;
    letter_t f;
    letter_t g;
    letter_t h;
    logic    ok;
  } adj_res_t;

  // 0..31 -> 0..25
  function automatic letter_t reduce_letter(input letter_t x);
    return (x >= letter_t'(Letters)) ? x - letter_t'(Letters) : x;
  endfunction

  // additive inverse mod 26
  function automatic letter_t neg_mod(input letter_t x);
    return (x == '0) ? '0 : letter_t'(Letters) - x;
  endfunction

  // (x + y) mod 26 for x, y in 0..25
  function automatic letter_t add_mod(input letter_t x, input letter_t y);
    logic [LetterW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= (LetterW+1)'(Letters)) begin
      s = s - (LetterW+1)'(Letters);
    end
    return s[LetterW-1:0];
  endfunction

  // product of two letters
  function automatic prod_t mul_letter(input letter_t x, input letter_t y);
    return prod_t'(x) * prod_t'(y);
  endfunction

  // x mod 26 for a product-width value: estimate, then one correction
  function automatic letter_t mod_prod(input prod_t x);
    logic [ScaledW-1:0] scaled;
    logic [QuotW-1:0]   q;
    prod_t              r;
    scaled = ScaledW'(x) * ScaledW'(Recip);
    q      = scaled[ScaledW-1:QuotSh];
    r      = x - prod_t'(q) * prod_t'(Letters);
    if (r >= prod_t'(Letters)) begin
      r = r - prod_t'(Letters);
    end
    return r[LetterW-1:0];
  endfunction

  // inverse mod 26; zero where the residue shares a factor with 26
  function automatic letter_t inv_lookup(input letter_t x);
    letter_t r;
    case (x)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/hill_2x2_key_recovery_top.sv
// ---------------------------------------------------------------------------
// hill_2x2_key_recovery_top: 2x2 Hill cipher key recovery, K = C * P^-1 mod 26
// Nine register stages lie between the input beat and the output beat.
// Throughput: one beat per cycle while the output side takes beats.
// A stalled output still lets the input fill any empty stage behind it.
// Reset (rst_ni low, async) clears all stage valid bits; data is not reset.
// ---------------------------------------------------------------------------
module hill_2x2_key_recovery_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input beat: plaintext P and ciphertext C
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hkr_pkg::letter_t p_00_i,
  input  hkr_pkg::letter_t p_01_i,
  input  hkr_pkg::letter_t p_10_i,
  input  hkr_pkg::letter_t p_11_i,
  input  hkr_pkg::letter_t c_00_i,
  input  hkr_pkg::letter_t c_01_i,
  input  hkr_pkg::letter_t c_10_i,
  input  hkr_pkg::letter_t c_11_i,
  // output beat: key K and the invertible flag
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hkr_pkg::letter_t k_00_o,
  output hkr_pkg::letter_t k_01_o,
  output hkr_pkg::letter_t k_10_o,
  output hkr_pkg::letter_t k_11_o,
  output logic             invertible_o
);

  // Pipeline map:
  //   det (4): letter reduce / ad, bc / mod 26 / det, inverse table
  //   adj (2): adjugate * inverse / mod 26
  //   mul (3): eight products / mod 26 / pair sums into output register
  // Each stage advances when empty or when the one after it advances, so
  // bubbles collapse under backpressure and no beat is dropped or repeated.

  logic              det_valid, det_ready;
  hkr_pkg::det_res_t det_res;
  logic              adj_valid, adj_ready;
  hkr_pkg::adj_res_t adj_res;

  hkr_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .p_00_i  (p_00_i),
    .p_01_i  (p_01_i),
    .p_10_i  (p_10_i),
    .p_11_i  (p_11_i),
    .c_00_i  (c_00_i),
    .c_01_i  (c_01_i),
    .c_10_i  (c_10_i),
    .c_11_i  (c_11_i),
    .valid_o (det_valid),
    .ready_i (det_ready),
    .res_o   (det_res)
  );

  // singular P: inverse is zero, so every entry below comes out zero
  hkr_adj u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (det_valid),
    .ready_o (det_ready),
    .res_i   (det_res),
    .valid_o (adj_valid),
    .ready_i (adj_ready),
    .res_o   (adj_res)
  );

  hkr_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (adj_valid),
    .ready_o      (adj_ready),
    .res_i        (adj_res),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .k_00_o       (k_00_o),
    .k_01_o       (k_01_o),
    .k_10_o       (k_10_o),
    .k_11_o       (k_11_o),
    .invertible_o (invertible_o)
  );

`ifndef SYNTHESIS
  // input only backs up when the whole pipe is full and the output is stalled
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled with room in the pipeline");

  // singular plaintext gives an all-zero key
  a_singular_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !invertible_o) |->
      (k_00_o == '0 && k_01_o == '0 && k_10_o == '0 && k_11_o == '0))
    else $error("nonzero key for singular plaintext");

  // key entries stay reduced
  a_key_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (k_00_o < 5'd26 && k_01_o < 5'd26 &&
                     k_10_o < 5'd26 && k_11_o < 5'd26))
    else $error("key entry out of range");

  // internal hand-offs never stall while the output is free
  a_inner_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> (det_ready && adj_ready))
    else $error("internal stage stalled with output ready");
`endif

endmodule

// File: hw/rtl/hkr_det.sv
// ---------------------------------------------------------------------------
// hkr_det: determinant and its inverse, four stages
// Reduce letters, multiply ad/bc, reduce mod 26, subtract and look up inverse.
// ---------------------------------------------------------------------------
module hkr_det (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hkr_pkg::letter_t    p_00_i,
  input  hkr_pkg::letter_t    p_01_i,
  input  hkr_pkg::letter_t    p_10_i,
  input  hkr_pkg::letter_t    p_11_i,
  input  hkr_pkg::letter_t    c_00_i,
  input  hkr_pkg::letter_t    c_01_i,
  input  hkr_pkg::letter_t    c_10_i,
  input  hkr_pkg::letter_t    c_11_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hkr_pkg::det_res_t   res_o
);

  localparam int unsigned NStg = 4;

  typedef struct packed {
    hkr_pkg::letter_t a;
    hkr_pkg::letter_t d;
    hkr_pkg::letter_t nb;
    hkr_pkg::letter_t nc;
    hkr_pkg::letter_t e;
    hkr_pkg::letter_t f;
    hkr_pkg::letter_t g;
    hkr_pkg::letter_t h;
  } carry_t;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  carry_t            car1_q, car2_q, car3_q;
  carry_t            car1_d;
  hkr_pkg::letter_t  b1_q, c1_q;
  hkr_pkg::prod_t    ad2_q, bc2_q;
  hkr_pkg::letter_t  ad3_q, bc3_q;
  hkr_pkg::det_res_t res_q;
  hkr_pkg::letter_t  det;
  hkr_pkg::letter_t  dinv;

  // a stage moves when empty or when the next one moves
  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NStg-1];
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    car1_d.a  = hkr_pkg::reduce_letter(p_00_i);
    car1_d.d  = hkr_pkg::reduce_letter(p_11_i);
    car1_d.nb = hkr_pkg::neg_mod(hkr_pkg::reduce_letter(p_01_i));
    car1_d.nc = hkr_pkg::neg_mod(hkr_pkg::reduce_letter(p_10_i));
    car1_d.e  = hkr_pkg::reduce_letter(c_00_i);
    car1_d.f  = hkr_pkg::reduce_letter(c_01_i);
    car1_d.g  = hkr_pkg::reduce_letter(c_10_i);
    car1_d.h  = hkr_pkg::reduce_letter(c_11_i);
  end

  assign det  = hkr_pkg::add_mod(ad3_q, hkr_pkg::neg_mod(bc3_q));
  assign dinv = hkr_pkg::inv_lookup(det);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      car1_q <= car1_d;
      b1_q   <= hkr_pkg::reduce_letter(p_01_i);
      c1_q   <= hkr_pkg::reduce_letter(p_10_i);
    end
    if (en[1]) begin
      car2_q <= car1_q;
      ad2_q  <= hkr_pkg::mul_letter(car1_q.a, car1_q.d);
      bc2_q  <= hkr_pkg::mul_letter(b1_q, c1_q);
    end
    if (en[2]) begin
      car3_q <= car2_q;
      ad3_q  <= hkr_pkg::mod_prod(ad2_q);
      bc3_q  <= hkr_pkg::mod_prod(bc2_q);
    end
    if (en[3]) begin
      res_q.a    <= car3_q.a;
      res_q.d    <= car3_q.d;
      res_q.nb   <= car3_q.nb;
      res_q.nc   <= car3_q.nc;
      res_q.e    <= car3_q.e;
      res_q.f    <= car3_q.f;
      res_q.g    <= car3_q.g;
      res_q.h    <= car3_q.h;
      res_q.dinv <= dinv;
      res_q.ok   <= (dinv != '0);
    end
  end

endmodule

// File: hw/rtl/hkr_adj.sv
// ---------------------------------------------------------------------------
// hkr_adj: inverse of P, two stages
// Scales the adjugate by the determinant inverse and reduces mod 26.
// ---------------------------------------------------------------------------
module hkr_adj (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hkr_pkg::det_res_t   res_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hkr_pkg::adj_res_t   res_o
);

  localparam int unsigned NStg = 2;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  hkr_pkg::prod_t    pd_q, pnb_q, pnc_q, pa_q;
  hkr_pkg::letter_t  e_q, f_q, g_q, h_q;
  logic              ok_q;
  hkr_pkg::adj_res_t res_q;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NStg-1];
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // a zero inverse zeroes every entry, so a singular P yields a zero key
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pd_q  <= hkr_pkg::mul_letter(res_i.d, res_i.dinv);
      pnb_q <= hkr_pkg::mul_letter(res_i.nb, res_i.dinv);
      pnc_q <= hkr_pkg::mul_letter(res_i.nc, res_i.dinv);
      pa_q  <= hkr_pkg::mul_letter(res_i.a, res_i.dinv);
      e_q   <= res_i.e;
      f_q   <= res_i.f;
      g_q   <= res_i.g;
      h_q   <= res_i.h;
      ok_q  <= res_i.ok;
    end
    if (en[1]) begin
      res_q.i00 <= hkr_pkg::mod_prod(pd_q);
      res_q.i01 <= hkr_pkg::mod_prod(pnb_q);
      res_q.i10 <= hkr_pkg::mod_prod(pnc_q);
      res_q.i11 <= hkr_pkg::mod_prod(pa_q);
      res_q.e   <= e_q;
      res_q.f   <= f_q;
      res_q.g   <= g_q;
      res_q.h   <= h_q;
      res_q.ok  <= ok_q;
    end
  end

endmodule

// File: hw/rtl/hkr_mul.sv
// ---------------------------------------------------------------------------
// hkr_mul: key product C * P^-1 mod 26, three stages
// Eight products, per-product reduction, pairwise modular sum into the output.
// ---------------------------------------------------------------------------
module hkr_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hkr_pkg::adj_res_t   res_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hkr_pkg::letter_t    k_00_o,
  output hkr_pkg::letter_t    k_01_o,
  output hkr_pkg::letter_t    k_10_o,
  output hkr_pkg::letter_t    k_11_o,
  output logic                invertible_o
);

  localparam int unsigned NStg  = 3;
  localparam int unsigned NProd = 8;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  hkr_pkg::prod_t   p7_q [NProd];
  hkr_pkg::letter_t r8_q [NProd];
  logic             ok7_q, ok8_q, ok9_q;
  hkr_pkg::letter_t k00_q, k01_q, k10_q, k11_q;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o      = en[0];
  assign valid_o      = v_q[NStg-1];
  assign k_00_o       = k00_q;
  assign k_01_o       = k01_q;
  assign k_10_o       = k10_q;
  assign k_11_o       = k11_q;
  assign invertible_o = ok9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // pairs (0,1) (2,3) (4,5) (6,7) feed k00 k01 k10 k11
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p7_q[0] <= hkr_pkg::mul_letter(res_i.e, res_i.i00);
      p7_q[1] <= hkr_pkg::mul_letter(res_i.f, res_i.i10);
      p7_q[2] <= hkr_pkg::mul_letter(res_i.e, res_i.i01);
      p7_q[3] <= hkr_pkg::mul_letter(res_i.f, res_i.i11);
      p7_q[4] <= hkr_pkg::mul_letter(res_i.g, res_i.i00);
      p7_q[5] <= hkr_pkg::mul_letter(res_i.h, res_i.i10);
      p7_q[6] <= hkr_pkg::mul_letter(res_i.g, res_i.i01);
      p7_q[7] <= hkr_pkg::mul_letter(res_i.h, res_i.i11);
      ok7_q   <= res_i.ok;
    end
    if (en[1]) begin
      for (int j = 0; j < NProd; j++) begin
        r8_q[j] <= hkr_pkg::mod_prod(p7_q[j]);
      end
      ok8_q <= ok7_q;
    end
    if (en[2]) begin
      k00_q <= hkr_pkg::add_mod(r8_q[0], r8_q[1]);
      k01_q <= hkr_pkg::add_mod(r8_q[2], r8_q[3]);
      k10_q <= hkr_pkg::add_mod(r8_q[4], r8_q[5]);
      k11_q <= hkr_pkg::add_mod(r8_q[6], r8_q[7]);
      ok9_q <= ok8_q;
    end
  end

endmodule

// File: tb/tb_hill_2x2_key_recovery_top.sv
// ---------------------------------------------------------------------------
// tb_hill_2x2_key_recovery_top: self-checking bench for 2x2 Hill key recovery
// Drives P/C matrix pairs through the valid/ready input with random idle
// bursts. Each key beat is checked against an in-bench mod-26 solver, except
// for directed rows whose expected key is written out in the table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hill_2x2_key_recovery_top;

  typedef hkr_pkg::letter_t letter_t;

  localparam int unsigned Letters = hkr_pkg::Letters;

  localparam int RandPairs  = 1150;
  localparam int QuietPairs = 100;   // last pairs sent with no idling anywhere
  localparam int DrainCyc   = 20;    // pipeline is nine deep
  localparam int MaxReports = 10;
  localparam int SegLen     = 64;

  typedef struct packed {
    letter_t p00;
    letter_t p01;
    letter_t p10;
    letter_t p11;
    letter_t c00;
    letter_t c01;
    letter_t c10;
    letter_t c11;
  } mat_pair_t;

  typedef struct packed {
    letter_t k00;
    letter_t k01;
    letter_t k10;
    letter_t k11;
    logic    inv;
  } key_t;

  typedef struct packed {
    mat_pair_t pair;
    logic      typed;  // expected key given in the row itself
    key_t      key;
  } plan_row_t;

  logic    clk;
  logic    rst_ni;
  logic    in_valid;
  logic    in_ready;
  letter_t p_00, p_01, p_10, p_11;
  letter_t c_00, c_01, c_10, c_11;
  logic    out_valid;
  logic    out_ready;
  letter_t k_00, k_01, k_10, k_11;
  logic    invertible;

  plan_row_t plan_q[$];
  key_t      key_q[$];    // keys owed by the block, oldest first
  int        mismatches;
  logic      quiet;       // no idling on either side once set

  hill_2x2_key_recovery_top DUT (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .p_00_i       (p_00),
    .p_01_i       (p_01),
    .p_10_i       (p_10),
    .p_11_i       (p_11),
    .c_00_i       (c_00),
    .c_01_i       (c_01),
    .c_10_i       (c_10),
    .c_11_i       (c_11),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .k_00_o       (k_00),
    .k_01_o       (k_01),
    .k_10_o       (k_10),
    .k_11_o       (k_11),
    .invertible_o (invertible)
  );

  // K = C * P^-1 mod 26; zero key and flag clear when det(P) is not a unit
  function automatic key_t recover_key(input mat_pair_t m);
    int unsigned a, b, c, d, e, f, g, h;
    int unsigned det, dinv, i00, i01, i10, i11;
    key_t k;
    a = m.p00 % Letters;
    b = m.p01 % Letters;
    c = m.p10 % Letters;
    d = m.p11 % Letters;
    e = m.c00 % Letters;
    f = m.c01 % Letters;
    g = m.c10 % Letters;
    h = m.c11 % Letters;
    // the added 26*26 keeps the difference from going negative
    det  = (a * d + Letters * Letters - b * c) % Letters;
    dinv = 0;
    for (int x = 1; x < Letters; x++) begin
      if ((det * x) % Letters == 1) begin
        dinv = x;
      end
    end
    k = '0;
    if (dinv != 0) begin
      i00 = (d * dinv) % Letters;
      i01 = (((Letters - b) % Letters) * dinv) % Letters;
      i10 = (((Letters - c) % Letters) * dinv) % Letters;
      i11 = (a * dinv) % Letters;
      k.k00 = letter_t'((e * i00 + f * i10) % Letters);
      k.k01 = letter_t'((e * i01 + f * i11) % Letters);
      k.k10 = letter_t'((g * i00 + h * i10) % Letters);
      k.k11 = letter_t'((g * i01 + h * i11) % Letters);
      k.inv = 1'b1;
    end
    return k;
  endfunction

  // mostly legal letters, now and then the raw 26..31 codes too
  function automatic letter_t draw_letter(input logic wide);
    return wide ? letter_t'($urandom_range(31)) : letter_t'($urandom_range(Letters - 1));
  endfunction

  function automatic mat_pair_t draw_pair();
    mat_pair_t m;
    logic      wide;
    wide  = ($urandom_range(99) < 15);
    m.p00 = draw_letter(wide);
    m.p01 = draw_letter(wide);
    m.p10 = draw_letter(wide);
    m.p11 = draw_letter(wide);
    m.c00 = draw_letter(wide);
    m.c01 = draw_letter(wide);
    m.c10 = draw_letter(wide);
    m.c11 = draw_letter(wide);
    return m;
  endfunction

  task automatic add_row(input mat_pair_t m, input logic typed, input key_t k);
    plan_q.push_back('{pair: m, typed: typed, key: k});
  endtask

  // directed rows: P first, then C, both by row then column
  task automatic build_plan();
    // all zero: det 0, singular
    add_row({5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}, 1'b1, '0);
    // identity P gives K = C
    add_row({5'd1, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd0}, 1'b1,
            {5'd0, 5'd0, 5'd0, 5'd0, 1'b1});
    add_row({5'd1, 5'd0, 5'd0, 5'd1, 5'd25, 5'd25, 5'd25, 5'd25}, 1'b1,
            {5'd25, 5'd25, 5'd25, 5'd25, 1'b1});
    // 31 folds to 5
    add_row({5'd1, 5'd0, 5'd0, 5'd1, 5'd31, 5'd31, 5'd31, 5'd31}, 1'b1,
            {5'd5, 5'd5, 5'd5, 5'd5, 1'b1});
    // rank-one P matrices, det 0
    add_row({5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25, 5'd25}, 1'b1, '0);
    add_row({5'd31, 5'd31, 5'd31, 5'd31, 5'd1, 5'd2, 5'd3, 5'd4}, 1'b1, '0);
    // det shares factor 2 or 13 with the modulus
    add_row({5'd2, 5'd0, 5'd0, 5'd1, 5'd7, 5'd8, 5'd9, 5'd10}, 1'b1, '0);
    add_row({5'd13, 5'd0, 5'd0, 5'd1, 5'd25, 5'd0, 5'd0, 5'd25}, 1'b1, '0);
    // 26 folds to 0, so det 0
    add_row({5'd26, 5'd0, 5'd0, 5'd27, 5'd3, 5'd5, 5'd7, 5'd11}, 1'b1, '0);
    // rest go through the solver: negative det, swaps, raw codes
    add_row({5'd1, 5'd0, 5'd0, 5'd25, 5'd3, 5'd4, 5'd5, 5'd6}, 1'b0, '0);
    add_row({5'd0, 5'd1, 5'd1, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4}, 1'b0, '0);
    add_row({5'd0, 5'd25, 5'd25, 5'd0, 5'd25, 5'd24, 5'd23, 5'd22}, 1'b0, '0);
    add_row({5'd27, 5'd28, 5'd29, 5'd30, 5'd31, 5'd30, 5'd29, 5'd28}, 1'b0, '0);
    add_row({5'd3, 5'd0, 5'd0, 5'd1, 5'd10, 5'd11, 5'd12, 5'd13}, 1'b0, '0);
    add_row({5'd5, 5'd17, 5'd8, 5'd3, 5'd19, 5'd7, 5'd2, 5'd14}, 1'b0, '0);
    add_row({5'd25, 5'd25, 5'd0, 5'd25, 5'd31, 5'd0, 5'd0, 5'd31}, 1'b0, '0);
    add_row({5'd7, 5'd11, 5'd2, 5'd9, 5'd0, 5'd25, 5'd25, 5'd0}, 1'b0, '0);
    add_row({5'd11, 5'd13, 5'd13, 5'd11, 5'd4, 5'd9, 5'd16, 5'd21}, 1'b0, '0);
    add_row({5'd17, 5'd16, 5'd16, 5'd17, 5'd16, 5'd16, 5'd16, 5'd16}, 1'b0, '0);
    add_row({5'd15, 5'd8, 5'd1, 5'd1, 5'd15, 5'd15, 5'd15, 5'd15}, 1'b0, '0);
  endtask

  // one input beat; returns at the accepting edge
  task automatic send_pair(input mat_pair_t m, input key_t k, input int idle_pct);
    int gap;
    @(negedge clk);
    if (!quiet && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    p_00     <= m.p00;
    p_01     <= m.p01;
    p_10     <= m.p10;
    p_11     <= m.p11;
    c_00     <= m.c00;
    c_01     <= m.c01;
    c_10     <= m.c10;
    c_11     <= m.c11;
    do begin
      @(posedge clk);
    end while (!in_ready);
    key_q.push_back(k);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    out_ready  = 1'b0;
    quiet      = 1'b0;
    mismatches = 0;
    {p_00, p_01, p_10, p_11, c_00, c_01, c_10, c_11} = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
  end

  // stimulus and end of run
  initial begin : stim
    mat_pair_t m;
    key_t      k;
    int        n_total;
    int        idle_pct;
    build_plan();
    n_total  = plan_q.size() + RandPairs;
    idle_pct = 0;
    @(posedge rst_ni);
    for (int i = 0; i < n_total; i++) begin
      if (i % SegLen == 0) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 40;
        endcase
      end
      if (i >= n_total - QuietPairs) begin
        quiet = 1'b1;
      end
      if (i < plan_q.size()) begin
        m = plan_q[i].pair;
        k = plan_q[i].typed ? plan_q[i].key : recover_key(m);
      end else begin
        m = draw_pair();
        k = recover_key(m);
      end
      send_pair(m, k, idle_pct);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (key_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCyc) @(posedge clk);
    if (mismatches == 0 && key_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // output side backpressure: random stall bursts
  initial begin : sink
    int stall_left;
    int stall_pct;
    int cyc;
    stall_left = 0;
    stall_pct  = 0;
    cyc        = 0;
    forever begin
      @(negedge clk);
      if (cyc % SegLen == 0) begin
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
      cyc++;
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // key beat checker
  always @(posedge clk) begin : check_keys
    key_t got;
    key_t want;
    if (rst_ni && out_valid && out_ready) begin
      got = {k_00, k_01, k_10, k_11, invertible};
      if (key_q.size() == 0) begin
        if (mismatches < MaxReports) begin
          $display("%0t: key beat with none pending: k=%0d %0d %0d %0d inv=%0b",
                   $realtime, got.k00, got.k01, got.k10, got.k11, got.inv);
        end
        mismatches++;
      end else begin
        want = key_q.pop_front();
        if (got !== want) begin
          if (mismatches < MaxReports) begin
            $display(
              "%0t: key mismatch: exp k=%0d %0d %0d %0d inv=%0b, got k=%0d %0d %0d %0d inv=%0b",
              $realtime, want.k00, want.k01, want.k10, want.k11, want.inv,
              got.k00, got.k01, got.k10, got.k11, got.inv);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/hkr_pkg.sv
hw/rtl/hkr_det.sv
hw/rtl/hkr_adj.sv
hw/rtl/hkr_mul.sv
hw/rtl/hill_2x2_key_recovery_top.sv
tb/tb_hill_2x2_key_recovery_top.sv
